// ===== hw/rtl/columnar_transposition_block_defines.svh =====
// Assertion macros shared by the columnar transposition block RTL.
`ifndef COLUMNAR_TRANSPOSITION_BLOCK_DEFINES_SVH
`define COLUMNAR_TRANSPOSITION_BLOCK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CTB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("columnar transposition check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("columnar transposition check failed");

`endif

// ===== hw/rtl/ctb_pkg.sv =====
// Shared types, constants and helpers of the columnar transposition block.
`timescale 1ns / 1ps

package ctb_pkg;

    // Field widths fixed by the register and payload formats
    localparam int BYTE_W      = 8;
    localparam int DIM_W       = 4;
    localparam int KEY_W       = 24;
    localparam int IDX_W       = 3;
    localparam int KEY_ENTRIES = 8;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int CALC_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd3;

    // Register reset values
    localparam logic [DIM_W-1:0] ROWS_RESET    = 4'd1;
    localparam logic [DIM_W-1:0] COLUMNS_RESET = 4'd1;
    localparam logic [KEY_W-1:0] KEY_RESET     = 24'hFAC688;
    localparam logic             MODE_RESET    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_LEN = 2'd1,
        ST_KEY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD
    } bk_state_t;

    // One classified block, handed from the loader to the emitter
    typedef struct packed {
        status_t            status;
        logic               encrypt;
        logic [DIM_W-1:0]   rows;
        logic [DIM_W-1:0]   cols;
        logic [KEY_W-1:0]   key;
    } job_t;

    // Column read at rank idx
    function automatic logic [IDX_W-1:0] key_entry(input logic [KEY_W-1:0] key,
                                                   input logic [IDX_W-1:0] idx);
        key_entry = key[IDX_W * idx +: IDX_W];
    endfunction

endpackage

// ===== hw/rtl/columnar_transposition_block.sv =====
// Top level of the columnar transposition block: loader, job queue, emitter, byte store.
// Loading writes each input byte to the store; the transfer marked block_end ends the block.
// Each result passes through a store read state (BK_READ) and then an output register load state
// (BK_LOAD); an error result is loaded into the output register directly from the queue head.
// Input is stalled from block_end until the last result of the block is loaded into the output register.
// Reset (rst_n low, asynchronous) restores register defaults and clears control; store is not cleared.
`timescale 1ns / 1ps

`include "columnar_transposition_block_defines.svh"

module columnar_transposition_block #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctb_pkg::KEY_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ctb_pkg::BYTE_W-1:0]     text_byte,
    input  logic                           block_end,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ctb_pkg::BYTE_W-1:0]     out_byte,
    output logic [1:0]                     status,
    output logic                           run_end
);
    import ctb_pkg::*;

    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic [STORE_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;
    logic                push;
    job_t                push_job;
    logic                pop;
    logic                q_not_empty;
    logic                q_full;
    job_t                q_head;
    logic                job_done;
    logic                front_stall;

    ctb_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .ADDR_W      (STORE_AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid && !q_full),
        .in_stall  (front_stall),
        .text_byte (text_byte),
        .block_end (block_end),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .push      (push),
        .push_job  (push_job),
        .job_done  (job_done)
    );

    // Queue full never occurs while one block is in flight; stall on it anyway
    assign in_stall = front_stall || q_full;

    ctb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (q_head)
    );

    ctb_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (STORE_AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ctb_back #(
        .ADDR_W (STORE_AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .job_done    (job_done),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .status      (status),
        .run_end     (run_end)
    );

    // Error results carry a zero byte and close the block
    `CTB_ASSERT_IMPL(a_error_result, out_valid && (status != ST_OK), run_end && (out_byte == '0))
    // A block end transfer locks the input until the block is emitted
    `CTB_ASSERT_NEXT(a_lock_after_end, in_valid && !in_stall && block_end, in_stall)
    // The job queue never holds more than the block in flight
    `CTB_ASSERT_IMPL(a_queue_single, q_not_empty, !q_full)

endmodule

// ===== hw/rtl/ctb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ctb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ctb_front.sv =====
// Loader: configuration registers, byte intake into the store, block classification.
`timescale 1ns / 1ps

module ctb_front #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    parameter int ADDR_W      = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctb_pkg::KEY_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ctb_pkg::BYTE_W-1:0]     text_byte,
    input  logic                           block_end,
    output logic                           ram_we,
    output logic [ADDR_W-1:0]              ram_waddr,
    output logic [ctb_pkg::BYTE_W-1:0]     ram_wdata,
    output logic                           push,
    output ctb_pkg::job_t                  push_job,
    input  logic                           job_done
);
    import ctb_pkg::*;

    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic [KEY_W-1:0] key_reg;
    logic             mode_reg;

    logic [CNT_W-1:0] count_reg, count_next, count_final;
    logic             overrun_reg, overrun_next;
    logic             busy_reg, busy_next;

    logic             in_xfer;
    logic             store_ok;
    logic             grid_bad;
    logic             key_bad;
    logic             len_bad;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLUMNS_RESET;
            key_reg  <= KEY_RESET;
            mode_reg <= MODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS:    rows_reg <= cfg_data[DIM_W-1:0];
                REG_COLUMNS: cols_reg <= cfg_data[DIM_W-1:0];
                REG_KEY:     key_reg  <= cfg_data;
                REG_MODE:    mode_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Intake: hold off while a loaded block waits to be emitted
    assign in_stall = busy_reg;
    assign in_xfer  = in_valid && !busy_reg;
    assign store_ok = count_reg < CNT_W'(STORE_DEPTH);

    assign ram_we    = in_xfer && store_ok;
    assign ram_waddr = count_reg[ADDR_W-1:0];
    assign ram_wdata = text_byte;

    assign count_final = store_ok ? count_reg + 1'b1 : count_reg;

    // Grid range check
    assign grid_bad = (rows_reg == '0) || (rows_reg > DIM_W'(MAX_ROWS)) ||
                      (cols_reg == '0) || (cols_reg > DIM_W'(MAX_COLUMNS));

    // Key check: used entries in range and pairwise distinct
    always_comb
    begin
        key_bad = 1'b0;
        for (int r = 0; r < KEY_ENTRIES; r++)
        begin
            if (DIM_W'(r) < cols_reg)
            begin
                if ({1'b0, key_entry(key_reg, IDX_W'(r))} >= cols_reg)
                begin
                    key_bad = 1'b1;
                end
                for (int s = r + 1; s < KEY_ENTRIES; s++)
                begin
                    if ((DIM_W'(s) < cols_reg) &&
                        (key_entry(key_reg, IDX_W'(r)) == key_entry(key_reg, IDX_W'(s))))
                    begin
                        key_bad = 1'b1;
                    end
                end
            end
        end
    end

    // Grid product is formed at full width so that 8 by 8 does not wrap
    assign len_bad = overrun_reg || !store_ok ||
                     (PROD_W'(count_final) != (PROD_W'(rows_reg) * PROD_W'(cols_reg)));

    // Job descriptor for the emitter
    assign push = in_xfer && block_end;

    always_comb
    begin
        push_job.encrypt = mode_reg;
        push_job.rows    = rows_reg;
        push_job.cols    = cols_reg;
        push_job.key     = key_reg;
        if (grid_bad)
        begin
            push_job.status = ST_LEN;
        end
        else if (key_bad)
        begin
            push_job.status = ST_KEY;
        end
        else if (len_bad)
        begin
            push_job.status = ST_LEN;
        end
        else
        begin
            push_job.status = ST_OK;
        end
    end

    // Byte count, overrun and busy tracking
    always_comb
    begin
        count_next   = count_reg;
        overrun_next = overrun_reg;
        busy_next    = busy_reg;
        if (in_xfer)
        begin
            if (block_end)
            begin
                count_next   = '0;
                overrun_next = 1'b0;
                busy_next    = 1'b1;
            end
            else
            begin
                count_next = count_final;
                if (!store_ok)
                begin
                    overrun_next = 1'b1;
                end
            end
        end
        if (job_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            overrun_reg <= 1'b0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            overrun_reg <= overrun_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

// ===== hw/rtl/ctb_queue.sv =====
// Two-entry job queue between the loader and the emitter.
`timescale 1ns / 1ps

module ctb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ctb_pkg::job_t push_job,
    input  logic          pop,
    output logic          not_empty,
    output logic          full,
    output ctb_pkg::job_t head
);
    import ctb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign not_empty = fill_reg != '0;
    assign full      = fill_reg == CNT_W'(QUEUE_DEPTH);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/ctb_back.sv =====
// Emitter: walks the stored block in transposed order and drives the output register.
`timescale 1ns / 1ps

module ctb_back #(
    parameter int ADDR_W = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_not_empty,
    input  ctb_pkg::job_t               q_head,
    output logic                        pop,
    output logic                        job_done,
    output logic [ADDR_W-1:0]           ram_raddr,
    input  logic [ctb_pkg::BYTE_W-1:0]  ram_rdata,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ctb_pkg::BYTE_W-1:0]  out_byte,
    output logic [1:0]                  status,
    output logic                        run_end
);
    import ctb_pkg::*;

    bk_state_t         state_reg, state_next;
    job_t              job_reg, job_next;
    logic [IDX_W-1:0]  outer_reg, outer_next;
    logic [IDX_W-1:0]  inner_reg, inner_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    status_t           status_reg, status_next;
    logic              run_end_reg, run_end_next;

    logic              out_free;
    logic [DIM_W-1:0]  inner_lim;
    logic [DIM_W-1:0]  outer_lim;
    logic              last_inner;
    logic              last_outer;
    logic [IDX_W-1:0]  rank;
    logic [DIM_W-1:0]  mul_a;
    logic [IDX_W-1:0]  mul_b;
    logic [IDX_W-1:0]  offset;
    logic [CALC_W-1:0] addr_full;

    assign out_free = !out_valid_reg || !out_stall;

    // Encrypt: outer = rank over columns, inner = row.
    // Decrypt: outer = row, inner = column.
    assign inner_lim  = job_reg.encrypt ? job_reg.rows : job_reg.cols;
    assign outer_lim  = job_reg.encrypt ? job_reg.cols : job_reg.rows;
    assign last_inner = {1'b0, inner_reg} == inner_lim - 1'b1;
    assign last_outer = {1'b0, outer_reg} == outer_lim - 1'b1;

    // Rank at which the current column is read
    always_comb
    begin
        rank = '0;
        for (int r = 0; r < KEY_ENTRIES; r++)
        begin
            if ((DIM_W'(r) < job_reg.cols) &&
                (key_entry(job_reg.key, IDX_W'(r)) == inner_reg))
            begin
                rank = IDX_W'(r);
            end
        end
    end

    // Store address
    assign mul_a     = job_reg.encrypt ? job_reg.cols : job_reg.rows;
    assign mul_b     = job_reg.encrypt ? inner_reg : rank;
    assign offset    = job_reg.encrypt ? key_entry(job_reg.key, outer_reg) : outer_reg;
    assign addr_full = CALC_W'(mul_a) * CALC_W'(mul_b) + CALC_W'(offset);
    assign ram_raddr = addr_full[ADDR_W-1:0];

    // Sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        outer_next     = outer_reg;
        inner_next     = inner_reg;
        pop            = 1'b0;
        job_done       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        status_next    = status_reg;
        run_end_next   = run_end_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty && out_free)
                begin
                    pop = 1'b1;
                    if (q_head.status != ST_OK)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        status_next    = q_head.status;
                        run_end_next   = 1'b1;
                        job_done       = 1'b1;
                    end
                    else
                    begin
                        job_next   = q_head;
                        outer_next = '0;
                        inner_next = '0;
                        state_next = BK_READ;
                    end
                end
            end
            BK_READ:
            begin
                if (out_free)
                begin
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = ram_rdata;
                status_next    = ST_OK;
                run_end_next   = last_inner && last_outer;
                state_next     = BK_READ;
                if (last_inner)
                begin
                    inner_next = '0;
                    if (last_outer)
                    begin
                        state_next = BK_IDLE;
                        job_done   = 1'b1;
                    end
                    else
                    begin
                        outer_next = outer_reg + 1'b1;
                    end
                end
                else
                begin
                    inner_next = inner_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        outer_reg    <= outer_next;
        inner_reg    <= inner_next;
        out_byte_reg <= out_byte_next;
        status_reg   <= status_next;
        run_end_reg  <= run_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;
    assign run_end   = run_end_reg;

endmodule
